FILE: design/peak_meter_db_ballistics_defines.svh
// assertion macros shared by the peak meter rtl
// expects clk and rst_n in the scope of each use
`ifndef PEAK_METER_DB_BALLISTICS_DEFINES_SVH
`define PEAK_METER_DB_BALLISTICS_DEFINES_SVH

// same-cycle implication, off during reset
`define PMDB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PMDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pmdb_pkg.sv
// types, sizes and constants for the peak meter with db mapping and ballistics
// no dependencies
`default_nettype none

package pmdb_pkg;

  // capacity and log precision
  localparam int MAX_CHANNELS   = 32;
  localparam int LOG_TABLE_BITS = 8;
  localparam int NUM_BANKS      = 2;
  localparam int DEPTH          = NUM_BANKS * MAX_CHANNELS;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int ITER_W         = (LOG_TABLE_BITS > 1) ? $clog2(LOG_TABLE_BITS) : 1;

  // field widths
  localparam int CH_W    = 5;
  localparam int CNT_W   = 6;
  localparam int PEAK_W  = 32;
  localparam int LEVEL_W = 17;
  localparam int COEF_W  = 16;
  localparam int EXP_W   = 5;
  localparam int MANT_W  = PEAK_W - 1;       // q1.30 mantissa
  localparam int LG_W    = EXP_W + LOG_TABLE_BITS;

  // db slope 20*log10(2)/60 in q0.24
  localparam int SLOPE_W  = 21;
  localparam logic [SLOPE_W-1:0] DB_SLOPE = SLOPE_W'(1683482);
  localparam int DPROD_W    = LG_W + SLOPE_W;
  localparam int DROP_SHIFT = 8 + LOG_TABLE_BITS;
  localparam int DROP_W     = DPROD_W + 1 - DROP_SHIFT;
  localparam logic [DPROD_W:0] DROP_RND = (DPROD_W + 1)'(1) << (7 + LOG_TABLE_BITS);
  localparam logic [LG_W-1:0] LOG_FULL  = LG_W'(PEAK_W - 1) << LOG_TABLE_BITS;
  localparam logic [EXP_W-1:0] EXP_TOP  = EXP_W'(PEAK_W - 1);

  // ballistic step
  localparam int BPROD_W = LEVEL_W + COEF_W;
  localparam logic [BPROD_W:0] BAL_RND = (BPROD_W + 1)'(1) << (COEF_W - 1);
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(65536);

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(1);
  localparam logic [COEF_W-1:0] ATTACK_RESET  = COEF_W'(43909);
  localparam logic [COEF_W-1:0] RELEASE_RESET = COEF_W'(17039);

  typedef struct packed {
    logic                bank;
    logic [CH_W-1:0]     channel;
    logic [CNT_W-1:0]    frame_channels;
    logic [PEAK_W-1:0]   peak;
  } pmdb_in_t;

  typedef struct packed {
    logic                out_bank;
    logic [CH_W-1:0]     out_channel;
    logic [LEVEL_W-1:0]  level;
  } pmdb_out_t;

  // normalized item queued between front and back
  typedef struct packed {
    logic                bank;
    logic [CH_W-1:0]     channel;
    logic [CNT_W-1:0]    frame_channels;
    logic                zero;
    logic [EXP_W-1:0]    exp;
    logic [MANT_W-1:0]   mant;
  } pmdb_job_t;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
  } pmdb_coef_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SQ,
    BS_DROP,
    BS_DIFF,
    BS_MUL,
    BS_FIN
  } pmdb_bstate_t;

endpackage

`default_nettype wire

FILE: design/pmdb_front.sv
// front end: normalizes the peak into exponent and mantissa and queues the job
// depends on pmdb_pkg
`default_nettype none

module pmdb_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  pmdb_pkg::pmdb_in_t  in_data,
  output logic                job_valid,
  input  wire                 job_pop,
  output pmdb_pkg::pmdb_job_t job
);

  pmdb_pkg::pmdb_job_t              norm;
  logic [pmdb_pkg::EXP_W-1:0]       msb;
  logic [pmdb_pkg::PEAK_W-1:0]      shifted;
  pmdb_pkg::pmdb_job_t              q_r [2];
  logic                             wr_ptr_r;
  logic                             rd_ptr_r;
  logic [1:0]                       cnt_r;
  logic                             push;

  // leading one position
  always_comb begin
    msb = '0;
    for (int i = 0; i < pmdb_pkg::PEAK_W; i++) begin
      if (in_data.peak[i]) msb = pmdb_pkg::EXP_W'(i);
    end
  end

  // mantissa with the leading one at the q1.30 integer bit
  assign shifted = in_data.peak << (pmdb_pkg::EXP_TOP - msb);

  always_comb begin
    norm.bank           = in_data.bank;
    norm.channel        = in_data.channel;
    norm.frame_channels = in_data.frame_channels;
    norm.zero           = (in_data.peak == '0);
    norm.exp            = msb;
    norm.mant           = shifted[pmdb_pkg::PEAK_W-1:1];
  end

  // two-entry job queue
  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= norm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (job_pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, job_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/pmdb_back.sv
// back end: log2 by repeated squaring, db mapping, ballistics and level store
// depends on pmdb_pkg and the assertion macros
`default_nettype none
`include "peak_meter_db_ballistics_defines.svh"

module pmdb_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  job_valid,
  input  pmdb_pkg::pmdb_job_t  job,
  output logic                 job_pop,
  input  pmdb_pkg::pmdb_coef_t coef,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pmdb_pkg::pmdb_out_t  out_data
);

  pmdb_pkg::pmdb_bstate_t state_r, state_nxt;

  // per-item working registers
  logic                              bank_r;
  logic [pmdb_pkg::CH_W-1:0]         channel_r;
  logic                              inside_r;
  logic [pmdb_pkg::IDX_W-1:0]        idx_r;
  logic                              zero_r;
  logic                              full_r;
  logic [pmdb_pkg::EXP_W-1:0]        exp_r;
  logic [pmdb_pkg::MANT_W-1:0]       mant_r;
  logic [pmdb_pkg::LOG_TABLE_BITS-1:0] frac_r;
  logic [pmdb_pkg::ITER_W-1:0]       iter_r;
  logic [pmdb_pkg::DPROD_W-1:0]      dprod_r;
  logic [pmdb_pkg::LEVEL_W-1:0]      tgt_r;
  logic [pmdb_pkg::LEVEL_W-1:0]      prev_r;
  logic [pmdb_pkg::LEVEL_W-1:0]      diff_r;
  logic                              up_r;
  logic [pmdb_pkg::BPROD_W-1:0]      bprod_r;

  // storage
  logic [pmdb_pkg::LEVEL_W-1:0]      level_mem [pmdb_pkg::DEPTH];
  logic [pmdb_pkg::LEVEL_W-1:0]      rd_data_r;
  logic [pmdb_pkg::DEPTH-1:0]        level_valid_r;
  logic [pmdb_pkg::CNT_W-1:0]        bank_count_r [pmdb_pkg::NUM_BANKS];

  logic                              out_valid_r;
  pmdb_pkg::pmdb_out_t               out_data_r;

  // control
  logic mem_we;
  logic out_load;
  logic last_iter;

  // combinational datapath
  logic                              pop_inside;
  logic [pmdb_pkg::IDX_W-1:0]        pop_ch;
  logic [pmdb_pkg::IDX_W-1:0]        pop_idx;
  logic                              pop_clear;
  logic [2*pmdb_pkg::MANT_W-1:0]     sq;
  logic [pmdb_pkg::LG_W-1:0]         lg;
  logic [pmdb_pkg::LG_W-1:0]         n_dist;
  logic [pmdb_pkg::DPROD_W:0]        dsum;
  logic [pmdb_pkg::DROP_W-1:0]       drop;
  logic [pmdb_pkg::LEVEL_W-1:0]      tgt;
  logic [pmdb_pkg::LEVEL_W-1:0]      prev;
  logic [pmdb_pkg::COEF_W-1:0]       coef_sel;
  logic [pmdb_pkg::BPROD_W:0]        bsum;
  logic [pmdb_pkg::LEVEL_W-1:0]      step;
  logic [pmdb_pkg::LEVEL_W-1:0]      level_nxt;

  // address of the incoming job
  assign pop_inside = (32'(job.channel) < 32'(pmdb_pkg::MAX_CHANNELS));
  assign pop_ch     = pop_inside ? pmdb_pkg::IDX_W'(job.channel) : '0;
  assign pop_idx    = job.bank ? (pmdb_pkg::IDX_W'(pmdb_pkg::MAX_CHANNELS) + pop_ch) : pop_ch;
  assign pop_clear  = (job.frame_channels != bank_count_r[job.bank]);

  // one squaring of the mantissa per cycle
  assign sq = (2*pmdb_pkg::MANT_W)'(mant_r) * (2*pmdb_pkg::MANT_W)'(mant_r);

  // distance below full scale in log2 units
  assign lg     = {exp_r, frac_r};
  assign n_dist = pmdb_pkg::LOG_FULL - lg;

  // target level from the scaled drop
  assign dsum = (pmdb_pkg::DPROD_W + 1)'(dprod_r) + pmdb_pkg::DROP_RND;
  assign drop = dsum[pmdb_pkg::DPROD_W:pmdb_pkg::DROP_SHIFT];

  always_comb begin
    if (zero_r) begin
      tgt = '0;
    end else if (full_r) begin
      tgt = pmdb_pkg::FULL_LEVEL;
    end else if (drop >= pmdb_pkg::DROP_W'(pmdb_pkg::FULL_LEVEL)) begin
      tgt = '0;
    end else begin
      tgt = pmdb_pkg::FULL_LEVEL - pmdb_pkg::LEVEL_W'(drop);
    end
  end

  // stored level, zero when the channel is out of range or the entry was cleared or never written
  assign prev = (inside_r && level_valid_r[idx_r]) ? rd_data_r : '0;

  // ballistic step
  assign coef_sel  = up_r ? coef.attack_coef : coef.release_coef;
  assign bsum      = (pmdb_pkg::BPROD_W + 1)'(bprod_r) + pmdb_pkg::BAL_RND;
  assign step      = pmdb_pkg::LEVEL_W'(bsum[pmdb_pkg::BPROD_W:pmdb_pkg::COEF_W]);
  assign level_nxt = up_r ? (prev_r + step) : (prev_r - step);

  assign last_iter = (iter_r == pmdb_pkg::ITER_W'(pmdb_pkg::LOG_TABLE_BITS - 1));

  // sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      pmdb_pkg::BS_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = pmdb_pkg::BS_SQ;
        end
      end
      pmdb_pkg::BS_SQ: begin
        if (last_iter) state_nxt = pmdb_pkg::BS_DROP;
      end
      pmdb_pkg::BS_DROP: state_nxt = pmdb_pkg::BS_DIFF;
      pmdb_pkg::BS_DIFF: state_nxt = pmdb_pkg::BS_MUL;
      pmdb_pkg::BS_MUL:  state_nxt = pmdb_pkg::BS_FIN;
      pmdb_pkg::BS_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          mem_we    = inside_r;
          state_nxt = pmdb_pkg::BS_IDLE;
        end
      end
      default: state_nxt = pmdb_pkg::BS_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= pmdb_pkg::BS_IDLE;
      out_valid_r     <= 1'b0;
      level_valid_r   <= '0;
      bank_count_r[0] <= '0;
      bank_count_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // count change clears the bank's valid bits
      if (job_pop && pop_clear) begin
        bank_count_r[job.bank] <= job.frame_channels;
        for (int b = 0; b < pmdb_pkg::NUM_BANKS; b++) begin
          for (int i = 0; i < pmdb_pkg::MAX_CHANNELS; i++) begin
            if (job.bank == b[0]) level_valid_r[b*pmdb_pkg::MAX_CHANNELS + i] <= 1'b0;
          end
        end
      end
      if (mem_we) level_valid_r[idx_r] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      pmdb_pkg::BS_IDLE: begin
        if (job_pop) begin
          bank_r    <= job.bank;
          channel_r <= job.channel;
          inside_r  <= pop_inside;
          idx_r     <= pop_idx;
          zero_r    <= job.zero;
          exp_r     <= job.exp;
          mant_r    <= job.mant;
          frac_r    <= '0;
          iter_r    <= '0;
        end
      end
      pmdb_pkg::BS_SQ: begin
        iter_r <= iter_r + pmdb_pkg::ITER_W'(1);
        frac_r <= {frac_r[pmdb_pkg::LOG_TABLE_BITS-2:0], sq[2*pmdb_pkg::MANT_W-1]};
        if (sq[2*pmdb_pkg::MANT_W-1]) begin
          mant_r <= sq[2*pmdb_pkg::MANT_W-1:pmdb_pkg::MANT_W];
        end else begin
          mant_r <= sq[2*pmdb_pkg::MANT_W-2:pmdb_pkg::MANT_W-1];
        end
      end
      pmdb_pkg::BS_DROP: begin
        full_r  <= (exp_r == pmdb_pkg::EXP_TOP);
        dprod_r <= pmdb_pkg::DPROD_W'(n_dist) * pmdb_pkg::DPROD_W'(pmdb_pkg::DB_SLOPE);
      end
      pmdb_pkg::BS_DIFF: begin
        tgt_r  <= tgt;
        prev_r <= prev;
        up_r   <= (tgt > prev);
        diff_r <= (tgt > prev) ? (tgt - prev) : (prev - tgt);
      end
      pmdb_pkg::BS_MUL: begin
        bprod_r <= pmdb_pkg::BPROD_W'(diff_r) * pmdb_pkg::BPROD_W'(coef_sel);
      end
      pmdb_pkg::BS_FIN: begin
        if (out_load) begin
          out_data_r.out_bank    <= bank_r;
          out_data_r.out_channel <= channel_r;
          out_data_r.level       <= level_nxt;
        end
      end
      default: ;
    endcase
  end

  // level memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) level_mem[idx_r] <= level_nxt;
    if (job_pop) rd_data_r <= level_mem[pop_idx];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PMDB_ASSERT_NEXT(a_fin_holds,
    (state_r == pmdb_pkg::BS_FIN) && out_valid_r && !out_ready,
    state_r == pmdb_pkg::BS_FIN,
    "result dropped while output register still full")
  `PMDB_ASSERT_NOW(a_step_bounded,
    state_r == pmdb_pkg::BS_FIN,
    up_r ? ((level_nxt >= prev_r) && (level_nxt <= tgt_r))
         : ((level_nxt <= prev_r) && (level_nxt >= tgt_r)),
    "ballistic step left the range between stored level and target")
  `PMDB_ASSERT_NOW(a_level_full,
    out_valid_r,
    out_data_r.level <= pmdb_pkg::FULL_LEVEL,
    "level above full scale")
  `PMDB_ASSERT_NEXT(a_sq_count,
    (state_r == pmdb_pkg::BS_SQ) && last_iter,
    state_r == pmdb_pkg::BS_DROP,
    "squaring loop ran past its bit count")

endmodule

`default_nettype wire

FILE: design/peak_meter_db_ballistics.sv
// An input transfer enters the front queue; the back end then pops it, runs
// LOG_TABLE_BITS squarings, drop, compare, step and write, and raises out_valid.
// The back end works on one item at a time, set by its single squaring multiplier,
// and waits on out_ready in its last step; the front queue holds two items meanwhile.
// Reset (synchronous, active low): coefficients to their defaults, all levels read
// as zero through cleared valid bits, channel counts zero, queue and output empty.
`default_nettype none

module peak_meter_db_ballistics (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  pmdb_pkg::pmdb_in_t              in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output pmdb_pkg::pmdb_out_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [pmdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [pmdb_pkg::COEF_W-1:0]      cfg_data
);

  logic                         job_valid;
  logic                         job_pop;
  pmdb_pkg::pmdb_job_t          job;
  pmdb_pkg::pmdb_coef_t         coef;
  logic [pmdb_pkg::COEF_W-1:0]  attack_coef_r;
  logic [pmdb_pkg::COEF_W-1:0]  release_coef_r;

  // coefficient registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coef_r  <= pmdb_pkg::ATTACK_RESET;
      release_coef_r <= pmdb_pkg::RELEASE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmdb_pkg::REG_ATTACK:  attack_coef_r  <= cfg_data;
        pmdb_pkg::REG_RELEASE: release_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef.attack_coef  = attack_coef_r;
  assign coef.release_coef = release_coef_r;

  pmdb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  pmdb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .coef      (coef),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
